// ----- hw/rtl/qfa_pkg.sv -----
`default_nettype none
package qfa_pkg;
   localparam int FRAC_BITS_DEF = 8;
   localparam int WORD_BITS_DEF = 32;
   localparam int ACT_BITS = 4;
   localparam logic [ACT_BITS-1:0] ACT_ADD = 4'd0;
   localparam logic [ACT_BITS-1:0] ACT_SUB = 4'd1;
   localparam logic [ACT_BITS-1:0] ACT_MUL = 4'd2;
   localparam logic [ACT_BITS-1:0] ACT_DIV = 4'd3;
   localparam logic [ACT_BITS-1:0] ACT_MIN = 4'd4;
   localparam logic [ACT_BITS-1:0] ACT_MAX = 4'd5;
   localparam logic [ACT_BITS-1:0] ACT_INC = 4'd6;
   localparam logic [ACT_BITS-1:0] ACT_DEC = 4'd7;
   localparam logic [ACT_BITS-1:0] ACT_TOINT = 4'd8;
   localparam logic [ACT_BITS-1:0] ACT_FROMINT = 4'd9;
endpackage
`default_nettype wire

// ----- hw/rtl/q24_8_fixed_point_alu_core.sv -----
// Path to rsp_valid: operand capture, divider stages, output register.
// Throughput: one request per cycle; busy is always low.
// Divide is a restoring divider unrolled one quotient bit per pipeline stage,
// the other actions ride along in delay stages of equal length.
// Reset (synchronous, active high) clears all valid bits; payload is not reset.
// The receiver cannot stall: each result shows for exactly one cycle.
`default_nettype none
module q24_8_fixed_point_alu_core
   import qfa_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF,
   parameter int WORD_BITS = WORD_BITS_DEF
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   output logic                     busy,
   input  wire logic [ACT_BITS-1:0] req_action,
   input  wire logic signed [31:0]  req_operand_a,
   input  wire logic signed [31:0]  req_operand_b,
   output logic                     rsp_valid,
   output logic signed [31:0]       rsp_result_value,
   output logic                     rsp_a_less,
   output logic                     rsp_a_equal,
   output logic                     rsp_a_greater,
   output logic                     rsp_divide_by_zero
);
   localparam int W = WORD_BITS;
   localparam int NW = WORD_BITS + FRAC_BITS;   // dividend width
   localparam int NS = NW;                      // divider stages

   typedef struct packed {
      logic [ACT_BITS-1:0] act;
      logic [W-1:0]        res;     // result of actions other than multiply and divide
      logic                lt;
      logic                eq;
      logic                gt;
      logic                nq;      // negate quotient
      logic                dz;
   } side_type;

   // stage 0: operand capture
   logic                 v0_ff;
   logic [ACT_BITS-1:0]  act0_ff;
   logic signed [W-1:0]  a0_ff, b0_ff;

   assign busy = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) v0_ff <= 1'b0;
      else v0_ff <= start;
      act0_ff <= req_action;
      a0_ff <= req_operand_a[W-1:0];
      b0_ff <= req_operand_b[W-1:0];
   end

   // stage 1: simple ops, product, divider setup
   side_type              s1_in;
   logic signed [2*W-1:0] prod;
   logic [W-1:0]          aabs, babs;

   always_comb begin
      aabs = a0_ff[W-1] ? W'(-a0_ff) : W'(a0_ff);
      babs = b0_ff[W-1] ? W'(-b0_ff) : W'(b0_ff);
      prod = (2*W)'(a0_ff) * (2*W)'(b0_ff);
      s1_in.act = act0_ff;
      s1_in.lt = a0_ff < b0_ff;
      s1_in.eq = a0_ff == b0_ff;
      s1_in.gt = a0_ff > b0_ff;
      s1_in.nq = a0_ff[W-1] ^ b0_ff[W-1];
      s1_in.dz = (act0_ff == ACT_DIV) && (b0_ff == '0);
      case (act0_ff)
         ACT_ADD:     s1_in.res = W'(a0_ff + b0_ff);
         ACT_SUB:     s1_in.res = W'(a0_ff - b0_ff);
         ACT_MIN:     s1_in.res = (a0_ff < b0_ff) ? a0_ff : b0_ff;
         ACT_MAX:     s1_in.res = (a0_ff > b0_ff) ? a0_ff : b0_ff;
         ACT_INC:     s1_in.res = W'(a0_ff + 1);
         ACT_DEC:     s1_in.res = W'(a0_ff - 1);
         ACT_TOINT:   s1_in.res = W'(a0_ff >>> FRAC_BITS);
         ACT_FROMINT: s1_in.res = W'(a0_ff <<< FRAC_BITS);
         default:     s1_in.res = '0;
      endcase
   end

   // divider stages: one quotient bit per stage, product rides along
   logic [NS:0]          vd_ff;
   side_type             sd_ff [NS+1];
   logic [W:0]           rem_ff [NS+1];
   logic [NW-1:0]        q_ff [NS+1];
   logic [W-1:0]         dv_ff [NS+1];
   logic [W-1:0]         pr_ff [NS+1];
   logic [W:0]           sh [NS];
   logic [W:0]           df [NS];

   always_comb begin
      for (int i = 0; i < NS; i++) begin
         sh[i] = {rem_ff[i][W-1:0], q_ff[i][NW-1]};
         df[i] = sh[i] - {1'b0, dv_ff[i]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) vd_ff <= '0;
      else vd_ff <= {vd_ff[NS-1:0], v0_ff};
      sd_ff[0] <= s1_in;
      rem_ff[0] <= '0;
      q_ff[0] <= {aabs, {FRAC_BITS{1'b0}}};
      dv_ff[0] <= babs;
      pr_ff[0] <= W'(prod >>> FRAC_BITS);
      for (int i = 0; i < NS; i++) begin
         sd_ff[i+1] <= sd_ff[i];
         dv_ff[i+1] <= dv_ff[i];
         pr_ff[i+1] <= pr_ff[i];
         rem_ff[i+1] <= df[i][W] ? sh[i] : df[i];
         q_ff[i+1] <= {q_ff[i][NW-2:0], ~df[i][W]};
      end
   end

   // output stage: select and sign the result
   logic [W-1:0] qw;
   logic [W-1:0] fin;
   always_comb begin
      qw = q_ff[NS][W-1:0];
      case (sd_ff[NS].act)
         ACT_MUL: fin = pr_ff[NS];
         ACT_DIV: fin = sd_ff[NS].dz ? '0 : (sd_ff[NS].nq ? W'(-qw) : qw);
         default: fin = sd_ff[NS].res;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid <= 1'b0;
      else rsp_valid <= vd_ff[NS];
      rsp_result_value <= 32'(signed'(fin));
      rsp_a_less <= sd_ff[NS].lt;
      rsp_a_equal <= sd_ff[NS].eq;
      rsp_a_greater <= sd_ff[NS].gt;
      rsp_divide_by_zero <= sd_ff[NS].dz;
   end
endmodule
`default_nettype wire

// ----- test/alu_result_checker.sv -----
`default_nettype none
module alu_result_checker
   import qfa_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   input  wire logic                busy,
   input  wire logic [ACT_BITS-1:0] req_action,
   input  wire logic signed [31:0]  req_operand_a,
   input  wire logic signed [31:0]  req_operand_b,
   input  wire logic                rsp_valid,
   input  wire logic signed [31:0]  rsp_result_value,
   input  wire logic                rsp_a_less,
   input  wire logic                rsp_a_equal,
   input  wire logic                rsp_a_greater,
   input  wire logic                rsp_divide_by_zero,
   output int                       mismatch_count,
   output int                       pending_count,
   output int                       result_count
);
   typedef struct packed {
      logic signed [31:0] value;
      logic               lt;
      logic               eq;
      logic               gt;
      logic               dz;
   } alu_result_type;

   alu_result_type expected_results[$];

   // Compute the fixed-point result for one request
   function automatic alu_result_type compute_result(logic [ACT_BITS-1:0] act,
                                                     logic signed [31:0] a,
                                                     logic signed [31:0] b);
      alu_result_type r;
      logic signed [63:0] wide;
      logic signed [63:0] num;
      r = '0;
      r.lt = a < b;
      r.eq = a == b;
      r.gt = a > b;
      case (act)
         ACT_ADD: r.value = a + b;
         ACT_SUB: r.value = a - b;
         ACT_MUL: begin
            wide = 64'(a) * 64'(b);
            wide = wide >>> 8;
            r.value = wide[31:0];
         end
         ACT_DIV: begin
            if (b == 0) begin
               r.dz = 1'b1;
            end else begin
               num = 64'(a) <<< 8;
               wide = num / 64'(b);
               r.value = wide[31:0];
            end
         end
         ACT_MIN: r.value = (a < b) ? a : b;
         ACT_MAX: r.value = (a > b) ? a : b;
         ACT_INC: r.value = a + 32'sd1;
         ACT_DEC: r.value = a - 32'sd1;
         ACT_TOINT: r.value = a >>> 8;
         ACT_FROMINT: r.value = a <<< 8;
         default: r.value = '0;
      endcase
      return r;
   endfunction

   assign pending_count = expected_results.size();

   // Queue predictions on accepted requests, compare results as they show
   always @(posedge clock) begin
      alu_result_type got;
      alu_result_type want;
      if (reset) begin
         mismatch_count <= 0;
         result_count <= 0;
      end else begin
         if (start && !busy)
            expected_results.push_back(compute_result(req_action, req_operand_a,
                                                      req_operand_b));
         if (rsp_valid) begin
            got = {rsp_result_value, rsp_a_less, rsp_a_equal, rsp_a_greater,
                   rsp_divide_by_zero};
            result_count <= result_count + 1;
            if (expected_results.size() == 0) begin
               if (mismatch_count < 10)
                  $display("unexpected result %h", got);
               mismatch_count <= mismatch_count + 1;
            end else begin
               want = expected_results.pop_front();
               if (got !== want) begin
                  if (mismatch_count < 10)
                     $display({"mismatch: expected val=%h lt%b eq%b gt%b dz%b,",
                               " got val=%h lt%b eq%b gt%b dz%b"},
                              want.value, want.lt, want.eq, want.gt, want.dz,
                              got.value, got.lt, got.eq, got.gt, got.dz);
                  mismatch_count <= mismatch_count + 1;
               end
            end
         end
      end
   end
endmodule
`default_nettype wire

// ----- test/tb_q24_8_fixed_point_alu_core.sv -----
`default_nettype none
module tb_q24_8_fixed_point_alu_core;
   import qfa_pkg::*;

   localparam int LATENCY = 43;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic [ACT_BITS-1:0] req_action = '0;
   logic signed [31:0] req_operand_a = '0;
   logic signed [31:0] req_operand_b = '0;
   wire logic busy;
   wire logic rsp_valid;
   wire logic signed [31:0] rsp_result_value;
   wire logic rsp_a_less, rsp_a_equal, rsp_a_greater, rsp_divide_by_zero;
   int mismatch_count, pending_count, result_count;
   int request_count = 0;

   q24_8_fixed_point_alu_core dut (.*);
   alu_result_checker checker_i (.*);

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Pick an operand with bias toward corner values
   function automatic logic [31:0] pick_operand();
      case ($urandom_range(0, 9))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return 32'(int'($urandom_range(0, 6)) - 3);
         3: return {24'(int'($urandom_range(0, 20)) - 10), 8'($urandom)};
         4: return 32'($urandom) >>> $urandom_range(0, 31);
         default: return $urandom;
      endcase
   endfunction

   // Drive one request and hold it until accepted
   task automatic send_request(logic [ACT_BITS-1:0] act, logic [31:0] a,
                               logic [31:0] b, bit keep_valid);
      start <= 1'b1;
      req_action <= act;
      req_operand_a <= a;
      req_operand_b <= b;
      @(posedge clock);
      while (busy) @(posedge clock);
      request_count++;
      if (!keep_valid) start <= 1'b0;
   endtask

   task automatic idle_burst();
      int n;
      n = $urandom_range(1, 17);
      start <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   initial begin
      logic [31:0] corner[6];
      int waited;
      corner = '{32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'h1, 32'hffff_ffff, 32'h100};
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // Directed: every action over corner operands, divide by zero, unused codes
      for (int act = 0; act < 16; act++)
         send_request(act[3:0], corner[act % 6], corner[(act + 2) % 6], 1'b1);
      send_request(ACT_DIV, 32'h7fff_ffff, 32'h0, 1'b1);
      send_request(ACT_DIV, 32'h8000_0000, 32'hffff_ffff, 1'b1);
      send_request(ACT_MUL, 32'h8000_0000, 32'h8000_0000, 1'b1);
      send_request(ACT_MIN, 32'h1234, 32'h1234, 1'b1);
      send_request(ACT_MAX, 32'hffff_ff00, 32'hffff_ff00, 1'b1);
      send_request(ACT_TOINT, 32'hffff_ff01, 32'h0, 1'b0);
      // Pause until every expected result has come
      while (pending_count != 0) @(posedge clock);
      // Random part, idling off in the last stretch
      for (int i = 0; i < 1200; i++) begin
         if (i < 1000 && $urandom_range(0, 9) == 0) idle_burst();
         send_request($urandom_range(0, 15) < 14 ? 4'($urandom_range(0, 9))
                                                 : 4'($urandom),
                      pick_operand(), pick_operand(), i != 1199);
      end
      waited = 0;
      while (pending_count != 0 && waited < 10 * LATENCY) begin
         @(posedge clock);
         waited++;
      end
      repeat (LATENCY) @(posedge clock);
      $display("covered %0d requests over all action codes, %0d results checked",
               request_count, result_count);
      if (mismatch_count == 0 && pending_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   initial begin
      #400000;
      $display("tb: failure");
      $finish;
   end
endmodule
`default_nettype wire
